### src/pmst_pkg.sv
// Shared types and constants for the minimum spanning tree engine.
package pmst_pkg;

    localparam int VERTEX_OUT_BITS = 6;
    localparam int WEIGHT_OUT_BITS = 32;
    localparam int TOTAL_BITS      = 38;
    localparam int COUNT_BITS      = 7;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]                  operation;
        logic [VERTEX_OUT_BITS-1:0]  from_vertex;
        logic [VERTEX_OUT_BITS-1:0]  to_vertex;
        logic [WEIGHT_OUT_BITS-1:0]  arc_weight;
    } request_t;

    typedef struct packed {
        logic [VERTEX_OUT_BITS-1:0]  tree_vertex;
        logic [VERTEX_OUT_BITS-1:0]  parent_vertex;
        logic [WEIGHT_OUT_BITS-1:0]  edge_weight;
        logic [TOTAL_BITS-1:0]       total_weight;
        logic                        reachable;
        logic                        last_result;
    } result_t;

    // Commands broadcast from the sequencer to every vertex cell
    typedef struct packed {
        logic init;
        logic mark;
        logic shift;
        logic apply;
    } cell_cmd_t;

endpackage

### src/pmst_arc_store.sv
// Adjacency store: one word per arc slot, presence flag over weight.
module pmst_arc_store
    import pmst_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 33,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/pmst_cell.sv
// One vertex cell: key, parent and marks, a link of the minimum-search chain
// and a stage of the adjacency-row shift chain.
module pmst_cell
    import pmst_pkg::*;
#(
    parameter int IDX          = 0,
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 32,
    localparam int VW          = $clog2(MAX_VERTICES),
    localparam int NW          = $clog2(MAX_VERTICES + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_cmd_t              cmd,
    input  logic [NW-1:0]          n_count,
    input  logic [VW-1:0]          pick,
    // search chain in
    input  logic                   cin_found,
    input  logic [WEIGHT_BITS-1:0] cin_key,
    input  logic [VW-1:0]          cin_idx,
    input  logic [VW-1:0]          cin_parent,
    input  logic                   cin_free_found,
    input  logic [VW-1:0]          cin_free_idx,
    // search chain out
    output logic                   cout_found,
    output logic [WEIGHT_BITS-1:0] cout_key,
    output logic [VW-1:0]          cout_idx,
    output logic [VW-1:0]          cout_parent,
    output logic                   cout_free_found,
    output logic [VW-1:0]          cout_free_idx,
    // row chain
    input  logic                   col_present_in,
    input  logic [WEIGHT_BITS-1:0] col_weight_in,
    output logic                   col_present_out,
    output logic [WEIGHT_BITS-1:0] col_weight_out
);

    localparam logic [VW-1:0] MY_IDX = VW'(IDX);

    logic                   valid_reg;
    logic                   visited_reg;
    logic [WEIGHT_BITS-1:0] key_reg;
    logic [VW-1:0]          parent_reg;
    logic                   col_present_reg;
    logic [WEIGHT_BITS-1:0] col_weight_reg;
    logic                   found_reg, found_next;
    logic [WEIGHT_BITS-1:0] ckey_reg, ckey_next;
    logic [VW-1:0]          cidx_reg, cidx_next;
    logic [VW-1:0]          cpar_reg, cpar_next;
    logic                   free_reg, free_next;
    logic [VW-1:0]          fidx_reg, fidx_next;
    logic                   in_use;
    logic                   lower;

    assign in_use = NW'(IDX) < n_count;
    assign lower  = in_use && !visited_reg && col_present_reg
                    && (!valid_reg || col_weight_reg < key_reg);

    // Fold this vertex into the running minimum and first free vertex
    always_comb
    begin
        found_next = cin_found;
        ckey_next  = cin_key;
        cidx_next  = cin_idx;
        cpar_next  = cin_parent;
        free_next  = cin_free_found;
        fidx_next  = cin_free_idx;
        if (in_use && !visited_reg)
        begin
            if (!cin_free_found)
            begin
                free_next = 1'b1;
                fidx_next = MY_IDX;
            end
            if (valid_reg && (!cin_found || key_reg < cin_key))
            begin
                found_next = 1'b1;
                ckey_next  = key_reg;
                cidx_next  = MY_IDX;
                cpar_next  = parent_reg;
            end
        end
    end

    // Hand the search result on to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ckey_reg <= ckey_next;
        cidx_reg <= cidx_next;
        cpar_reg <= cpar_next;
        fidx_reg <= fidx_next;
    end

    // Marks: clear on run start, but cell 0 starts valid; set visited on pick, validate on lowering
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            visited_reg <= 1'b0;
        end
        else if (cmd.init)
        begin
            valid_reg   <= (IDX == 0);
            visited_reg <= 1'b0;
        end
        else if (cmd.mark && pick == MY_IDX)
        begin
            visited_reg <= 1'b1;
        end
        else if (cmd.apply && lower)
        begin
            valid_reg <= 1'b1;
        end
    end

    // Key and parent
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            key_reg    <= '0;
            parent_reg <= '0;
        end
        else if (cmd.apply && lower)
        begin
            key_reg    <= col_weight_reg;
            parent_reg <= pick;
        end
    end

    // Advance the row chain
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            col_present_reg <= col_present_in;
            col_weight_reg  <= col_weight_in;
        end
    end

    assign cout_found      = found_reg;
    assign cout_key        = ckey_reg;
    assign cout_idx        = cidx_reg;
    assign cout_parent     = cpar_reg;
    assign cout_free_found = free_reg;
    assign cout_free_idx   = fidx_reg;
    assign col_present_out = col_present_reg;
    assign col_weight_out  = col_weight_reg;

endmodule

### src/prim_minimum_spanning_tree.sv
// Minimum spanning tree engine: top level with sequencer and vertex cell chain.
//
// Requests are taken when start is high and busy is low. Clear and reset each
// run a clearing pass over the whole adjacency store with busy high. An
// add-arc request reads the store, then merge-writes it. A run emits one
// result per vertex on result_valid for a single cycle each; the receiver must
// take them as they come. Every round waits for the minimum to ripple through
// the chain of vertex cells, and a round that reaches a vertex, other than the
// last round, then streams its adjacency row into the chain through the single
// store read port. The vertex_count register may be written at any time
// through cfg_valid and cfg_ready; it takes effect at the next run.
module prim_minimum_spanning_tree
    import pmst_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  request_t              request,
    output logic                  result_valid,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_BITS-1:0] cfg_data
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (WEIGHT_BITS > TOTAL_BITS) ? WEIGHT_BITS : TOTAL_BITS;
    localparam int MW    = WEIGHT_BITS + 1;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_ARC   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_TAIL  = 7'b0100000,
        S_APPLY = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          cnt_reg, cnt_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [NW-1:0]          round_reg, round_next;
    logic [VW-1:0]          pick_reg, pick_next;
    logic [TOTAL_BITS-1:0]  total_reg, total_next;
    logic [COUNT_BITS-1:0]  vcount_reg;
    logic                   rd_fire_reg;
    logic [AW-1:0]          arc_addr_reg;
    logic [WEIGHT_BITS-1:0] arc_w_reg;
    logic                   res_valid_reg;
    result_t                result_reg;

    logic                   accept;
    logic                   arc_ok;
    logic [AW-1:0]          arc_addr;
    logic [WEIGHT_BITS-1:0] arc_w;
    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [MW-1:0]          mem_wdata, mem_rdata;
    logic [VW-1:0]          load_col;
    logic [NW-1:0]          n_eff;
    cell_cmd_t              cmd;
    logic                   decide;
    logic                   reach;
    logic [VW-1:0]          pick_now;
    logic [VW-1:0]          pick_cell;
    logic [SW-1:0]          sum_ext;
    logic [SW-1:0]          key_ext;
    logic                   last_round;

    // Chain wiring
    logic                   ch_found  [MAX_VERTICES+1];
    logic [WEIGHT_BITS-1:0] ch_key    [MAX_VERTICES+1];
    logic [VW-1:0]          ch_idx    [MAX_VERTICES+1];
    logic [VW-1:0]          ch_parent [MAX_VERTICES+1];
    logic                   ch_free   [MAX_VERTICES+1];
    logic [VW-1:0]          ch_fidx   [MAX_VERTICES+1];
    logic                   col_p     [MAX_VERTICES+1];
    logic [WEIGHT_BITS-1:0] col_w     [MAX_VERTICES+1];

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= COUNT_BITS'(1);
        end
        else if (cfg_valid)
        begin
            vcount_reg <= cfg_data;
        end
    end

    // Clamp the vertex count into 1..MAX_VERTICES
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(vcount_reg) > 32'(MAX_VERTICES))
        begin
            n_eff = NW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = NW'(vcount_reg);
        end
    end

    // Arc address and weight of an add request
    assign arc_ok   = (32'(request.from_vertex) < 32'(MAX_VERTICES))
                      && (32'(request.to_vertex) < 32'(MAX_VERTICES));
    assign arc_addr = AW'(VW'(request.from_vertex)) * AW'(MAX_VERTICES)
                      + AW'(VW'(request.to_vertex));
    assign arc_w    = WEIGHT_BITS'(request.arc_weight);
    assign load_col = VW'(AW'(MAX_VERTICES - 1) - cnt_reg);

    // Store port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = arc_addr;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_ARC)
        begin
            mem_we    = 1'b1;
            mem_waddr = arc_addr_reg;
            if (mem_rdata[MW-1] && mem_rdata[WEIGHT_BITS-1:0] < arc_w_reg)
            begin
                mem_wdata = {1'b1, mem_rdata[WEIGHT_BITS-1:0]};
            end
            else
            begin
                mem_wdata = {1'b1, arc_w_reg};
            end
        end
        if (accept && request.operation == OP_ADD && arc_ok)
        begin
            mem_re = 1'b1;
        end
        else if (state_reg == S_LOAD)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pick_reg) * AW'(MAX_VERTICES) + AW'(load_col);
        end
    end

    pmst_arc_store #(
        .DEPTH (DEPTH),
        .WIDTH (MW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Head of the chains
    assign ch_found[0]  = 1'b0;
    assign ch_key[0]    = '0;
    assign ch_idx[0]    = '0;
    assign ch_parent[0] = '0;
    assign ch_free[0]   = 1'b0;
    assign ch_fidx[0]   = '0;
    assign col_p[0]     = mem_rdata[MW-1];
    assign col_w[0]     = mem_rdata[WEIGHT_BITS-1:0];

    // Present the fresh pick to the cells on the mark edge
    assign pick_cell = cmd.mark ? pick_now : pick_reg;

    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        pmst_cell #(
            .IDX          (i),
            .MAX_VERTICES (MAX_VERTICES),
            .WEIGHT_BITS  (WEIGHT_BITS)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .cmd             (cmd),
            .n_count         (n_reg),
            .pick            (pick_cell),
            .cin_found       (ch_found[i]),
            .cin_key         (ch_key[i]),
            .cin_idx         (ch_idx[i]),
            .cin_parent      (ch_parent[i]),
            .cin_free_found  (ch_free[i]),
            .cin_free_idx    (ch_fidx[i]),
            .cout_found      (ch_found[i+1]),
            .cout_key        (ch_key[i+1]),
            .cout_idx        (ch_idx[i+1]),
            .cout_parent     (ch_parent[i+1]),
            .cout_free_found (ch_free[i+1]),
            .cout_free_idx   (ch_fidx[i+1]),
            .col_present_in  (col_p[i]),
            .col_weight_in   (col_w[i]),
            .col_present_out (col_p[i+1]),
            .col_weight_out  (col_w[i+1])
        );
    end

    // Round decision from the chain tail
    assign decide     = (state_reg == S_SCAN) && (cnt_reg == AW'(MAX_VERTICES));
    assign reach      = ch_found[MAX_VERTICES];
    assign pick_now   = reach ? ch_idx[MAX_VERTICES] : ch_fidx[MAX_VERTICES];
    assign key_ext    = SW'(ch_key[MAX_VERTICES]);
    assign sum_ext    = SW'(total_reg) + key_ext;
    assign last_round = (round_reg == n_reg - NW'(1));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        round_next = round_reg;
        pick_next  = pick_reg;
        total_next = total_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (request.operation)
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_ADD:
                        begin
                            if (arc_ok)
                            begin
                                state_next = S_ARC;
                            end
                        end
                        OP_RUN:
                        begin
                            cmd.init   = 1'b1;
                            n_next     = n_eff;
                            round_next = '0;
                            total_next = '0;
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ARC:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (decide)
                begin
                    cmd.mark   = 1'b1;
                    pick_next  = pick_now;
                    cnt_next   = '0;
                    round_next = round_reg + NW'(1);
                    if (reach)
                    begin
                        total_next = sum_ext[TOTAL_BITS-1:0];
                    end
                    if (last_round)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (reach)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.shift = rd_fire_reg;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == AW'(MAX_VERTICES - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                cmd.shift  = rd_fire_reg;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_SCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state, read-fire flag and result strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            n_reg         <= NW'(1);
            round_reg     <= '0;
            total_reg     <= '0;
            rd_fire_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            round_reg     <= round_next;
            total_reg     <= total_next;
            rd_fire_reg   <= (state_reg == S_LOAD);
            res_valid_reg <= decide;
        end
    end

    // Hold the merge operands and the result payload
    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        if (accept)
        begin
            arc_addr_reg <= arc_addr;
            arc_w_reg    <= arc_w;
        end
        if (decide)
        begin
            result_reg.tree_vertex   <= VERTEX_OUT_BITS'(32'(pick_now));
            result_reg.last_result   <= last_round;
            result_reg.reachable     <= reach;
            if (reach)
            begin
                result_reg.parent_vertex <=
                    VERTEX_OUT_BITS'(32'(ch_parent[MAX_VERTICES]));
                result_reg.edge_weight   <= key_ext[WEIGHT_OUT_BITS-1:0];
                result_reg.total_weight  <= sum_ext[TOTAL_BITS-1:0];
            end
            else
            begin
                result_reg.parent_vertex <= '0;
                result_reg.edge_weight   <= '0;
                result_reg.total_weight  <= total_reg;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = result_reg;

endmodule

### tb/prim_minimum_spanning_tree_tb.sv
// Self-checking testbench for the minimum spanning tree engine.
`timescale 1ns / 100ps

module prim_minimum_spanning_tree_tb
    import pmst_pkg::*;
();

    localparam int NV         = 64;
    localparam int SETTLE     = 300;
    localparam int CYCLE_CAP  = 4000000;
    localparam int RAND_ITEMS = 90;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        bit                  is_cfg;
        logic [COUNT_BITS-1:0] cfg;
        request_t            req;
        bit                  typed;
        result_t             res;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    request_t              request = '0;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [COUNT_BITS-1:0] cfg_data = '0;

    // Tree model state
    logic [31:0]           arc_wt [NV*NV];
    bit                    arc_on [NV*NV];
    logic [31:0]           key_of [NV];
    bit                    key_ok [NV];
    logic [5:0]            parent_of [NV];
    bit                    done_v [NV];
    logic [37:0]           tree_sum;
    logic [COUNT_BITS-1:0] vcount = COUNT_BITS'(1);

    result_t               pending_rows [$];
    result_t               scratch [$];
    int                    errors = 0;
    int                    cycles = 0;
    int                    sender_gap = 33;
    int                    accepted = 0;

    prim_minimum_spanning_tree i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Grow the expected tree for one run command into scratch
    function automatic void grow_tree();
        int n, rnd, v, pick, first_free, idx;
        result_t r;
        n = (vcount == 0) ? 1 : (vcount > NV) ? NV : int'(vcount);
        scratch.delete();
        for (v = 0; v < NV; v++)
        begin
            key_ok[v] = 0;
            done_v[v] = 0;
        end
        tree_sum = '0;
        key_of[0] = '0;
        parent_of[0] = '0;
        key_ok[0] = 1;
        for (rnd = 0; rnd < n; rnd++)
        begin
            pick = n;
            first_free = n;
            for (v = 0; v < n; v++)
            begin
                if (done_v[v])
                    continue;
                if (first_free == n)
                    first_free = v;
                if (key_ok[v] && (pick == n || key_of[v] < key_of[pick]))
                    pick = v;
            end
            r = '0;
            if (pick != n)
            begin
                done_v[pick] = 1;
                tree_sum = tree_sum + 38'(key_of[pick]);
                r.tree_vertex   = 6'(pick);
                r.parent_vertex = parent_of[pick];
                r.edge_weight   = key_of[pick];
                r.reachable     = 1'b1;
                for (v = 0; v < n; v++)
                begin
                    idx = pick * NV + v;
                    if (done_v[v] || !arc_on[idx])
                        continue;
                    if (!key_ok[v] || arc_wt[idx] < key_of[v])
                    begin
                        key_of[v] = arc_wt[idx];
                        parent_of[v] = 6'(pick);
                        key_ok[v] = 1;
                    end
                end
            end
            else
            begin
                done_v[first_free] = 1;
                r.tree_vertex = 6'(first_free);
            end
            r.total_weight = tree_sum;
            r.last_result  = (rnd + 1 == n);
            scratch = {scratch, r};
        end
    endfunction

    // Apply one accepted request to the model
    function automatic void model_request(request_t rq);
        int idx;
        scratch.delete();
        case (rq.operation)
            OP_CLEAR:
                for (idx = 0; idx < NV*NV; idx++)
                    arc_on[idx] = 0;
            OP_ADD:
            begin
                idx = int'(rq.from_vertex) * NV + int'(rq.to_vertex);
                if (!arc_on[idx] || rq.arc_weight < arc_wt[idx])
                    arc_wt[idx] = rq.arc_weight;
                arc_on[idx] = 1;
            end
            OP_RUN:
                grow_tree();
            default: ;
        endcase
    endfunction

    // Hand one request to the block, idling first at random
    task automatic issue(request_t rq, bit typed, result_t typed_res);
        if ($urandom_range(99) < sender_gap)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do @(posedge clk); while (busy);
        model_request(rq);
        if (typed)
            pending_rows = {pending_rows, typed_res};
        else
            pending_rows = {pending_rows, scratch};
        if (rq.operation != OP_SPARE)
            accepted++;
    endtask

    // Drain the block, then write the vertex count
    task automatic write_count(logic [COUNT_BITS-1:0] val);
        start <= 1'b0;
        @(posedge clk);
        while (pending_rows.size() != 0 || busy) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        vcount = val;
    endtask

    function automatic request_t mk(logic [1:0] op, int a, int b, logic [31:0] w);
        request_t rq;
        rq.operation   = op;
        rq.from_vertex = 6'(a);
        rq.to_vertex   = 6'(b);
        rq.arc_weight  = w;
        return rq;
    endfunction

    // Check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_valid)
        begin
            if (pending_rows.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors++;
            end
            else
            begin
                e = pending_rows.pop_front();
                if (result.tree_vertex !== e.tree_vertex)
                begin
                    $error("tree_vertex exp %0d got %0d", e.tree_vertex, result.tree_vertex);
                    errors++;
                end
                if (result.parent_vertex !== e.parent_vertex)
                begin
                    $error("parent_vertex exp %0d got %0d",
                           e.parent_vertex, result.parent_vertex);
                    errors++;
                end
                if (result.edge_weight !== e.edge_weight)
                begin
                    $error("edge_weight exp %0h got %0h", e.edge_weight, result.edge_weight);
                    errors++;
                end
                if (result.total_weight !== e.total_weight)
                begin
                    $error("total_weight exp %0h got %0h",
                           e.total_weight, result.total_weight);
                    errors++;
                end
                if (result.reachable !== e.reachable)
                begin
                    $error("reachable exp %0b got %0b", e.reachable, result.reachable);
                    errors++;
                end
                if (result.last_result !== e.last_result)
                begin
                    $error("last_result exp %0b got %0b", e.last_result, result.last_result);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        step_t   plan [$];
        step_t   s;
        result_t root;
        request_t rq;
        int      n, k, a, b;
        logic [31:0] w;

        foreach (arc_on[i]) arc_on[i] = 0;
        root = '0;
        root.reachable   = 1'b1;
        root.last_result = 1'b1;

        // Directed table: config rows and requests
        s = '{default: '0};
        s.is_cfg = 1; s.cfg = 7'd0; plan = {plan, s};
        s = '{default: '0};
        s.req = mk(OP_RUN, 0, 0, 0); s.typed = 1; s.res = root; plan = {plan, s};
        s = '{default: '0};
        s.is_cfg = 1; s.cfg = 7'd3; plan = {plan, s};
        s = '{default: '0};
        s.req = mk(OP_ADD, 0, 1, 32'hFFFF_FFFF); plan = {plan, s};
        s.req = mk(OP_ADD, 1, 0, 32'hFFFF_FFFF); plan = {plan, s};
        s.req = mk(OP_ADD, 0, 1, 5); plan = {plan, s};
        s.req = mk(OP_ADD, 0, 1, 9); plan = {plan, s};
        s.req = mk(OP_ADD, 0, 2, 5); plan = {plan, s};
        s.req = mk(OP_ADD, 2, 2, 0); plan = {plan, s};
        s.req = mk(OP_SPARE, 63, 63, 32'hFFFF_FFFF); plan = {plan, s};
        s.req = mk(OP_RUN, 0, 0, 0); plan = {plan, s};
        s.req = mk(OP_CLEAR, 0, 0, 0); plan = {plan, s};
        s.req = mk(OP_ADD, 0, 2, 0); plan = {plan, s};
        s.req = mk(OP_RUN, 0, 0, 0); plan = {plan, s};
        s = '{default: '0};
        s.is_cfg = 1; s.cfg = 7'd127; plan = {plan, s};
        s = '{default: '0};
        s.req = mk(OP_ADD, 63, 0, 0); plan = {plan, s};
        s.req = mk(OP_ADD, 0, 63, 32'hFFFF_FFFF); plan = {plan, s};
        s.req = mk(OP_ADD, 63, 62, 1); plan = {plan, s};
        s.req = mk(OP_RUN, 0, 0, 0); plan = {plan, s};
        s = '{default: '0};
        s.is_cfg = 1; s.cfg = 7'd64; plan = {plan, s};
        s = '{default: '0};
        s.req = mk(OP_CLEAR, 0, 0, 0); plan = {plan, s};
        s.req = mk(OP_RUN, 0, 0, 0); plan = {plan, s};

        // Hold reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_count(plan[i].cfg);
            else
                issue(plan[i].req, plan[i].typed, plan[i].res);
        end

        // Random graphs: mostly well-formed load and run sequences
        accepted = 0;
        while (accepted < RAND_ITEMS)
        begin
            sender_gap = (accepted < 30) ? 33 : (accepted < 60) ? 81 : 0;
            n = ($urandom_range(11) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            write_count(7'(n));
            if ($urandom_range(2) == 0)
                issue(mk(OP_CLEAR, 0, 0, 0), 0, root);
            k = (n <= 8) ? $urandom_range(n, 3 * n) : $urandom_range(8, 24);
            repeat (k)
            begin
                if (accepted >= RAND_ITEMS)
                    break;
                if ($urandom_range(7) == 0)
                begin
                    a = $urandom_range(63);
                    b = $urandom_range(63);
                end
                else
                begin
                    a = $urandom_range(n - 1);
                    b = $urandom_range(n - 1);
                end
                w = $urandom_range(1) ? 32'($urandom_range(15)) : 32'($urandom);
                if ($urandom_range(15) == 0)
                    issue(mk(OP_SPARE, a, b, w), 0, root);
                issue(mk(OP_ADD, a, b, w), 0, root);
                if ($urandom_range(1))
                    issue(mk(OP_ADD, b, a, w), 0, root);
            end
            issue(mk(OP_RUN, $urandom_range(63), $urandom_range(63), $urandom), 0, root);
        end

        // Drain and settle
        start <= 1'b0;
        @(posedge clk);
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
src/pmst_pkg.sv
src/pmst_arc_store.sv
src/pmst_cell.sv
src/prim_minimum_spanning_tree.sv
tb/prim_minimum_spanning_tree_tb.sv
